// ===== src/all_pkg.sv =====
`default_nettype none
package all_pkg;
   localparam logic [3:0] CMD_INS_POS    = 4'd0;
   localparam logic [3:0] CMD_INS_FIRST  = 4'd1;
   localparam logic [3:0] CMD_INS_LAST   = 4'd2;
   localparam logic [3:0] CMD_INS_SORTED = 4'd3;
   localparam logic [3:0] CMD_DEL_POS    = 4'd4;
   localparam logic [3:0] CMD_DEL_FIRST  = 4'd5;
   localparam logic [3:0] CMD_DEL_LAST   = 4'd6;
   localparam logic [3:0] CMD_DEL_VALUE  = 4'd7;
   localparam logic [3:0] CMD_READ       = 4'd8;
   localparam logic [3:0] CMD_UPDATE     = 4'd9;
   localparam logic [3:0] CMD_FIND       = 4'd10;
   localparam logic [3:0] CMD_CLEAR      = 4'd11;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_POS   = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // Commands from the controller to the cell array.
   typedef struct packed {
      logic exec;   // perform the latched command on the array
   } all_cmd_type;

   // Status from the cell array to the controller.
   typedef struct packed {
      logic done;   // result register holds a finished word
   } all_sts_type;
endpackage
`default_nettype wire

// ===== src/all_ctrl.sv =====
`default_nettype none
module all_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output all_pkg::all_cmd_type cmd,
   output logic                load
);
   import all_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      load      = 1'b0;
      cmd.exec  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               load     = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/all_cells.sv =====
`default_nettype none
module all_cells #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         load,
   input  all_pkg::all_cmd_type        cmd,
   input  wire [3:0]                   req_cmd,
   input  wire [4:0]                   req_position,
   input  wire signed [WORD_BITS-1:0]  req_value,
   input  wire [4:0]                   capacity,
   output logic [2:0]                  rsp_status,
   output logic signed [WORD_BITS-1:0] rsp_result_value,
   output logic [4:0]                  rsp_found_index,
   output logic [4:0]                  rsp_count
);
   import all_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic signed [WORD_BITS-1:0] cell_ff [DEPTH];
   logic [CW-1:0]               count_ff;
   logic [3:0]                  op_ff;
   logic [4:0]                  pos_ff;
   logic signed [WORD_BITS-1:0] val_ff;

   // Per-cell compare results, taken together by priority encoders.
   logic [DEPTH-1:0] live, eq_v, gt_v;
   logic [CW-1:0]    eq_at, gt_at, at, lim;
   logic             eq_hit, full, pos_ok, ins_pos_ok;
   logic             do_ins, do_del, do_upd;
   logic [CW-1:0]    new_count;
   logic [2:0]       status;
   logic signed [WORD_BITS-1:0] rv;
   logic [4:0]       fidx;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         live[i] = CW'(i) < count_ff;
         eq_v[i] = live[i] && (cell_ff[i] == val_ff);
         gt_v[i] = live[i] && (cell_ff[i] > val_ff);
      end
      eq_at = '0; eq_hit = 1'b0;
      gt_at = count_ff;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (eq_v[i]) begin
            eq_at = CW'(i); eq_hit = 1'b1;
         end
         if (gt_v[i]) gt_at = CW'(i);
      end
      lim  = ({27'd0, capacity} > 32'(DEPTH)) ? CW'(DEPTH) : CW'(capacity);
      full = count_ff >= lim;
      pos_ok     = (pos_ff != 5'd0) && ({27'd0, pos_ff} <= 32'(count_ff));
      ins_pos_ok = (pos_ff != 5'd0) && ({27'd0, pos_ff} <= 32'(count_ff) + 32'd1);
      status = ST_OK; rv = '0; fidx = '0; at = '0;
      do_ins = 1'b0; do_del = 1'b0; do_upd = 1'b0;
      new_count = count_ff;
      unique case (op_ff)
         CMD_INS_POS, CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_SORTED: begin
            case (op_ff)
               CMD_INS_POS:    at = CW'(pos_ff - 5'd1);
               CMD_INS_LAST:   at = count_ff;
               CMD_INS_SORTED: at = gt_at;
               default:        at = '0;
            endcase
            if (op_ff == CMD_INS_POS && !ins_pos_ok) status = ST_BAD_POS;
            else if (full) status = ST_FULL;
            else begin
               do_ins = 1'b1; new_count = count_ff + 1'b1;
            end
         end
         CMD_DEL_POS: begin
            at = CW'(pos_ff - 5'd1);
            if (!pos_ok) status = ST_BAD_POS;
            else do_del = 1'b1;
         end
         CMD_DEL_FIRST, CMD_DEL_LAST: begin
            at = (op_ff == CMD_DEL_FIRST) ? '0 : count_ff - 1'b1;
            if (count_ff == '0) status = ST_EMPTY;
            else do_del = 1'b1;
         end
         CMD_DEL_VALUE, CMD_FIND: begin
            at = eq_at;
            if (count_ff == '0) status = ST_EMPTY;
            else if (!eq_hit) status = ST_NOT_FOUND;
            else if (op_ff == CMD_DEL_VALUE) do_del = 1'b1;
            else fidx = 5'(eq_at);
         end
         CMD_READ, CMD_UPDATE: begin
            at = CW'(pos_ff - 5'd1);
            if (!pos_ok) status = ST_BAD_POS;
            else if (op_ff == CMD_READ) rv = cell_ff[at[IW-1:0]];
            else do_upd = 1'b1;
         end
         CMD_CLEAR: new_count = '0;
         default: ;
      endcase
      if (do_del) begin
         rv = cell_ff[at[IW-1:0]];
         new_count = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff  <= req_cmd;
         pos_ff <= req_position;
         val_ff <= req_value;
      end
      if (cmd.exec) begin
         rsp_status       <= status;
         rsp_result_value <= rv;
         rsp_found_index  <= fidx;
         rsp_count        <= 5'(new_count);
         for (int i = 0; i < DEPTH; i++) begin
            if (do_ins) begin
               if (CW'(i) == at) cell_ff[i] <= val_ff;
               else if (CW'(i) > at && i > 0) cell_ff[i] <= cell_ff[(i > 0) ? i - 1 : 0];
            end else if (do_del) begin
               if (CW'(i) >= at && i < DEPTH - 1)
                  cell_ff[i] <= cell_ff[(i < DEPTH - 1) ? i + 1 : i];
            end else if (do_upd && CW'(i) == at) begin
               cell_ff[i] <= val_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= new_count;
      end
   end
endmodule
`default_nettype wire

// ===== src/array_linear_list_top.sv =====
`default_nettype none
// Fixed-capacity ordered list of signed words held in a chain of cells.
// Each command word returns exactly one result word carrying a status, a
// removed or read value, a match index and the entry count after the command.
// A command passes through the controller states in order: idle, in which it
// is accepted and latched; exec, in which every cell compares and shifts in
// parallel while priority encoders pick the target cell and the result word
// is registered; and resp, in which the result word is offered. A stalled
// result holds the block in resp until it is taken.
// Commands are handled one at a time, so the next word is taken once the
// result has been taken. The capacity register may be written at any time
// the list is idle; values above DEPTH behave as DEPTH.
module array_linear_list_top #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire [3:0]                   req_cmd,
   input  wire [4:0]                   req_position,
   input  wire signed [WORD_BITS-1:0]  req_value,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [2:0]                  rsp_status,
   output logic signed [WORD_BITS-1:0] rsp_result_value,
   output logic [4:0]                  rsp_found_index,
   output logic [4:0]                  rsp_count,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire [4:0]                   csr_data
);
   import all_pkg::*;

   all_cmd_type cmd;
   logic        load;
   logic [4:0]  capacity_ff;

   // The capacity register always accepts a write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 5'd16;
      end else if (csr_valid) begin
         capacity_ff <= csr_data;
      end
   end

   all_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .load      (load)
   );

   all_cells #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_cells (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .cmd              (cmd),
      .req_cmd          (req_cmd),
      .req_position     (req_position),
      .req_value        (req_value),
      .capacity         (capacity_ff),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_found_index  (rsp_found_index),
      .rsp_count        (rsp_count)
   );
endmodule
`default_nettype wire
